// File: rtl/trsmm_pkg.sv
// ============================================================================
// trsmm_pkg: shared types, constants and helpers of the model-matrix builder
// Holds the request and result item types, the queue entry, the Horner
// tables of the sine and cosine unit and the rounded trig product.
// ============================================================================
package trsmm_pkg;

  // Fraction bits of sine and cosine.
  localparam int TRIG_BITS = 16;
  // Signed trig value width: magnitude reaches 1.0.
  localparam int TRIG_W    = TRIG_BITS + 2;
  // Rotation element width: a sum of two trig products.
  localparam int RM_W      = TRIG_BITS + 3;
  // Width of a rotation element times a scale factor.
  localparam int PROD_W    = RM_W + 32;

  // Angle reduction, units of 1/64 degree.
  localparam logic [16:0] FULL_TURN    = 17'd23040;
  localparam logic [16:0] TWO_TURNS    = 17'd46080;
  localparam logic [16:0] THREE_TURNS  = 17'd69120;
  localparam logic [16:0] QUARTER_TURN = 17'd5760;
  localparam logic [16:0] HALF_TURN    = 17'd11520;
  localparam logic [16:0] THREE_QUARTERS = 17'd17280;

  // Radian conversion: x = round(r * pi / (2 * 5760)) in Q30, split as
  // r * X_A + floor((r * X_B + X_C) / X_DIV) with X_DIV = 45 * 2^18.
  localparam logic [63:0] PI_Q40 = 64'h3243F6A8886;
  localparam logic [63:0] X_DIV  = 64'd11796480;
  localparam logic [18:0] X_A    = 19'(PI_Q40 / X_DIV);
  localparam logic [23:0] X_B    = 24'(PI_Q40 % X_DIV);
  localparam logic [23:0] X_C    = 24'd5898240;
  localparam logic [26:0] M45    = 27'(64'd4294967296 / 64'd45);

  localparam logic [31:0] Q30_ONE = 32'd1073741824;

  // Horner divisors, step 0 is the innermost term (k = 8).
  localparam logic [8:0] D_S [8] = '{9'd272, 9'd210, 9'd156, 9'd110,
                                     9'd72, 9'd42, 9'd20, 9'd6};
  localparam logic [8:0] D_C [8] = '{9'd240, 9'd182, 9'd132, 9'd90,
                                     9'd56, 9'd30, 9'd12, 9'd2};
  // Reciprocals floor(2^32 / d) for the quotient estimate.
  localparam logic [31:0] R_S [8] = '{
    32'(64'd4294967296 / 64'd272), 32'(64'd4294967296 / 64'd210),
    32'(64'd4294967296 / 64'd156), 32'(64'd4294967296 / 64'd110),
    32'(64'd4294967296 / 64'd72),  32'(64'd4294967296 / 64'd42),
    32'(64'd4294967296 / 64'd20),  32'(64'd4294967296 / 64'd6)};
  localparam logic [31:0] R_C [8] = '{
    32'(64'd4294967296 / 64'd240), 32'(64'd4294967296 / 64'd182),
    32'(64'd4294967296 / 64'd132), 32'(64'd4294967296 / 64'd90),
    32'(64'd4294967296 / 64'd56),  32'(64'd4294967296 / 64'd30),
    32'(64'd4294967296 / 64'd12),  32'(64'd4294967296 / 64'd2)};

  // Row 3, column 3 holds 1.0 in Q16.16.
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] translate_x;
    logic signed [31:0] translate_y;
    logic signed [31:0] translate_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] element_value;
    logic               last_element;
  } out_item_t;

  // Classified request: per angle the quadrant and the radian remainder.
  typedef struct packed {
    logic [2:0][30:0] x;
    logic [2:0][1:0]  quad;
    logic [2:0][31:0] tr;
    logic [2:0][31:0] sc;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Product of two trig values, rounded half up to TRIG_BITS fraction bits.
  function automatic logic signed [TRIG_W-1:0] tmul(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = p + (2*TRIG_W)'(64'd1 << (TRIG_BITS - 1));
    return TRIG_W'(p >>> TRIG_BITS);
  endfunction

endpackage

// File: rtl/trsmm_front.sv
// ============================================================================
// trsmm_front: request intake and angle classification
// Reduces each angle to a quadrant and converts the remainder to radians in
// Q30 over three pipeline stages, then pushes the request into the queue.
// ============================================================================
module trsmm_front import trsmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      push_o,
  output q_item_t   push_data_o,
  input  logic      full_i
);

  typedef struct packed {
    logic [1:0]  quad;
    logic [12:0] rem;
  } red_t;

  // Wrap an angle into one turn and split it into quadrant and remainder.
  function automatic red_t reduce(input logic signed [15:0] a);
    logic [17:0] v;
    logic [16:0] u;
    red_t        res;
    v = 18'($signed({{2{a[15]}}, a})) + 18'd46080;
    if (v[16:0] >= THREE_TURNS) begin
      u = v[16:0] - THREE_TURNS;
    end else if (v[16:0] >= TWO_TURNS) begin
      u = v[16:0] - TWO_TURNS;
    end else if (v[16:0] >= FULL_TURN) begin
      u = v[16:0] - FULL_TURN;
    end else begin
      u = v[16:0];
    end
    if (u >= THREE_QUARTERS) begin
      res.quad = 2'd3;
      res.rem  = 13'(u - THREE_QUARTERS);
    end else if (u >= HALF_TURN) begin
      res.quad = 2'd2;
      res.rem  = 13'(u - HALF_TURN);
    end else if (u >= QUARTER_TURN) begin
      res.quad = 2'd1;
      res.rem  = 13'(u - QUARTER_TURN);
    end else begin
      res.quad = 2'd0;
      res.rem  = 13'(u);
    end
    return res;
  endfunction

  logic              advance;
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [2:0][1:0]   s1_quad_q, s2_quad_q, s3_quad_q;
  logic [2:0][12:0]  s1_rem_q;
  logic [2:0][31:0]  s1_tr_q, s2_tr_q, s3_tr_q;
  logic [2:0][31:0]  s1_sc_q, s2_sc_q, s3_sc_q;
  logic [2:0][30:0]  s2_ra_q, s3_ra_q;
  logic [2:0][18:0]  s2_t_q, s3_t_q;
  logic [2:0][45:0]  s3_e_q;
  red_t [2:0]        red;
  logic [2:0][30:0]  ra_d;
  logic [2:0][18:0]  t_d;
  logic [2:0][45:0]  e_d;
  logic [2:0][30:0]  x_d;

  // The pipeline moves as a whole unless a finished request cannot be queued.
  assign advance    = !s3_v_q || !full_i;
  assign in_stall_o = !advance;
  assign push_o     = s3_v_q && !full_i;

  // Per-angle datapath.
  always_comb begin
    logic [31:0] ra_full;
    logic [36:0] rb;
    logic [13:0] q0;
    logic [18:0] rem45;
    logic [13:0] qf;
    red[0] = reduce(in_data_i.angle_x);
    red[1] = reduce(in_data_i.angle_y);
    red[2] = reduce(in_data_i.angle_z);
    for (int n = 0; n < 3; n++) begin
      ra_full = 32'(s1_rem_q[n]) * 32'(X_A);
      ra_d[n] = ra_full[30:0];
      rb      = 37'(s1_rem_q[n]) * 37'(X_B) + 37'(X_C);
      t_d[n]  = rb[36:18];
      e_d[n]  = 46'(s2_t_q[n]) * 46'(M45);
      // Quotient estimate by 45 is low by at most one.
      q0      = s3_e_q[n][45:32];
      rem45   = s3_t_q[n] - 19'(q0) * 19'd45;
      qf      = q0 + 14'(rem45 >= 19'd45);
      x_d[n]  = s3_ra_q[n] + 31'(qf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int n = 0; n < 3; n++) begin
        s1_quad_q[n] <= red[n].quad;
        s1_rem_q[n]  <= red[n].rem;
      end
      s1_tr_q   <= {in_data_i.translate_z, in_data_i.translate_y, in_data_i.translate_x};
      s1_sc_q   <= {in_data_i.scale_z, in_data_i.scale_y, in_data_i.scale_x};
      s2_quad_q <= s1_quad_q;
      s2_tr_q   <= s1_tr_q;
      s2_sc_q   <= s1_sc_q;
      s2_ra_q   <= ra_d;
      s2_t_q    <= t_d;
      s3_quad_q <= s2_quad_q;
      s3_tr_q   <= s2_tr_q;
      s3_sc_q   <= s2_sc_q;
      s3_ra_q   <= s2_ra_q;
      s3_t_q    <= s2_t_q;
      s3_e_q    <= e_d;
    end
  end

  assign push_data_o.x    = x_d;
  assign push_data_o.quad = s3_quad_q;
  assign push_data_o.tr   = s3_tr_q;
  assign push_data_o.sc   = s3_sc_q;

endmodule

// File: rtl/trsmm_queue.sv
// ============================================================================
// trsmm_queue: two-entry request queue
// Decouples the classifying front from the matrix back end.
// ============================================================================
module trsmm_queue import trsmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_data_i,
  input  logic    pop_i,
  output q_item_t pop_data_o,
  output q_stat_t stat_o
);

  q_item_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/trsmm_trig.sv
// ============================================================================
// trsmm_trig: iterative sine and cosine unit
// Evaluates the Taylor series by Horner's scheme in unsigned Q30, sine and
// cosine side by side, each step in the states MUL, DIV and CORR, and applies the quadrant.
// ============================================================================
module trsmm_trig import trsmm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [30:0]              x_i,
  input  logic [1:0]               quad_i,
  output logic                     ready_o,
  output logic                     valid_o,
  input  logic                     take_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CORR = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [62:0] HALF_Q30 = 63'd536870912;
  localparam logic [30:0] RND_HALF = 31'(64'd1 << (29 - TRIG_BITS));

  logic [2:0]  state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic [30:0] x_q;
  logic [1:0]  quad_q;
  logic [31:0] x2_q;
  logic [30:0] ts_q, tc_q;
  logic [62:0] ps_q, pc_q;
  logic [31:0] ns_q, nc_q;
  logic [63:0] es_q, ec_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  logic [62:0] ps_rnd, pc_rnd;
  logic [31:0] ns_d, nc_d;
  logic [30:0] ts_new, tc_new;
  logic signed [TRIG_W-1:0] s_mag, c_mag;

  // One correction step of a Horner term: quotient fix-up and 1 - q.
  function automatic logic [30:0] horner_step(input logic [31:0] n,
                                              input logic [63:0] e,
                                              input logic [8:0]  d);
    logic [31:0] q0;
    logic [40:0] rem;
    logic [31:0] qf;
    q0  = e[63:32];
    rem = 41'(n) - 41'(q0) * 41'(d);
    qf  = q0 + 32'(rem >= 41'(d));
    return (qf > Q30_ONE) ? 31'd0 : 31'(Q30_ONE - qf);
  endfunction

  assign ready_o = (state_q == ST_IDLE);
  assign valid_o = (state_q == ST_DONE);
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

  // Rounded Q30 products and step arithmetic.
  always_comb begin
    logic [30:0] s30;
    logic [30:0] sr, cr;
    ps_rnd = ps_q + HALF_Q30;
    pc_rnd = pc_q + HALF_Q30;
    ns_d   = ps_rnd[61:30] + 32'(D_S[idx_q] >> 1);
    nc_d   = pc_rnd[61:30] + 32'(D_C[idx_q] >> 1);
    ts_new = horner_step(ns_q, es_q, D_S[idx_q]);
    tc_new = horner_step(nc_q, ec_q, D_C[idx_q]);
    s30    = ps_rnd[60:30];
    sr     = s30 + RND_HALF;
    cr     = tc_q + RND_HALF;
    s_mag  = TRIG_W'(sr >> (30 - TRIG_BITS));
    c_mag  = TRIG_W'(cr >> (30 - TRIG_BITS));
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SQR;
      ST_SQR: begin
        state_d = ST_MUL;
        idx_d   = 3'd0;
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_CORR;
      ST_CORR: begin
        if (idx_q == 3'd7) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
          idx_d   = idx_q + 3'd1;
        end
      end
      ST_FIN:  state_d = ST_RND;
      ST_RND:  state_d = ST_DONE;
      ST_DONE: if (take_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q    <= x_i;
        quad_q <= quad_i;
        ps_q   <= 63'(x_i) * 63'(x_i);
      end
      ST_SQR: begin
        x2_q <= ps_rnd[61:30];
        ts_q <= Q30_ONE[30:0];
        tc_q <= Q30_ONE[30:0];
      end
      ST_MUL: begin
        ps_q <= 63'(x2_q) * 63'(ts_q);
        pc_q <= 63'(x2_q) * 63'(tc_q);
      end
      ST_DIV: begin
        ns_q <= ns_d;
        nc_q <= nc_d;
        es_q <= 64'(ns_d) * 64'(R_S[idx_q]);
        ec_q <= 64'(nc_d) * 64'(R_C[idx_q]);
      end
      ST_CORR: begin
        ts_q <= ts_new;
        tc_q <= tc_new;
      end
      ST_FIN: ps_q <= 63'(x_q) * 63'(ts_q);
      ST_RND: begin
        case (quad_q)
          2'd0: begin
            sin_q <= s_mag;
            cos_q <= c_mag;
          end
          2'd1: begin
            sin_q <= c_mag;
            cos_q <= -s_mag;
          end
          2'd2: begin
            sin_q <= -s_mag;
            cos_q <= -c_mag;
          end
          default: begin
            sin_q <= -c_mag;
            cos_q <= s_mag;
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/trsmm_back.sv
// ============================================================================
// trsmm_back: trig, rotation and element emission
// Runs three sine and cosine units on the queue head, forms the rotation in
// two stages and streams the sixteen elements of T*R*S through an output
// register while the next request is already in the trig units.
// ============================================================================
module trsmm_back import trsmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_item_t   q_data_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic signed [PROD_W-1:0] S32_MAX  = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] S32_MIN  = -PROD_W'(64'sd2147483648);
  localparam logic signed [PROD_W-1:0] SC_HALF  = PROD_W'(64'd1 << (TRIG_BITS - 1));

  logic [2:0] tg_ready, tg_valid;
  logic signed [TRIG_W-1:0] tg_sin [3];
  logic signed [TRIG_W-1:0] tg_cos [3];
  logic start, take;
  logic [2:0][31:0] tg_tr_q, tg_sc_q;

  logic r1_v_q, r2_v_q, r1_move, r2_move;
  logic signed [TRIG_W-1:0] r1_czsy_q, r1_szsy_q, r1_rm00_q, r1_rm10_q, r1_rm21_q;
  logic signed [TRIG_W-1:0] r1_rm22_q, r1_szcx_q, r1_szsx_q, r1_czcx_q, r1_czsx_q;
  logic signed [TRIG_W-1:0] r1_sx_q, r1_cx_q, r1_sy_q;
  logic [2:0][31:0] r1_tr_q, r1_sc_q, r2_tr_q, r2_sc_q;
  logic signed [RM_W-1:0] r2_rm_q [3][3];

  logic signed [RM_W-1:0] em_rm_q [3][3];
  logic [2:0][31:0] em_tr_q, em_sc_q;
  logic [3:0] k_q;
  logic em_act_q, em_go, em_free;
  logic out_v_q;
  out_item_t out_q;
  logic signed [31:0] elem;

  // Three trig units run in lockstep, one per angle.
  for (genvar g = 0; g < 3; g++) begin : g_trig
    trsmm_trig u_trig (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .x_i     (q_data_i.x[g]),
      .quad_i  (q_data_i.quad[g]),
      .ready_o (tg_ready[g]),
      .valid_o (tg_valid[g]),
      .take_i  (take),
      .sin_o   (tg_sin[g]),
      .cos_o   (tg_cos[g])
    );
  end

  // Hand-off between stages.
  assign start   = (&tg_ready) && !q_stat_i.empty;
  assign pop_o   = start;
  assign em_go   = em_act_q && (!out_v_q || !out_stall_i);
  assign em_free = !em_act_q || (em_go && (k_q == 4'd15));
  assign r2_move = r2_v_q && em_free;
  assign r1_move = r1_v_q && (!r2_v_q || r2_move);
  assign take    = (&tg_valid) && (!r1_v_q || r1_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q   <= 1'b0;
      r2_v_q   <= 1'b0;
      em_act_q <= 1'b0;
      k_q      <= 4'd0;
      out_v_q  <= 1'b0;
    end else begin
      if (take) r1_v_q <= 1'b1;
      else if (r1_move) r1_v_q <= 1'b0;
      if (r1_move) r2_v_q <= 1'b1;
      else if (r2_move) r2_v_q <= 1'b0;
      if (r2_move) begin
        em_act_q <= 1'b1;
        k_q      <= 4'd0;
      end else if (em_go) begin
        if (k_q == 4'd15) em_act_q <= 1'b0;
        k_q <= k_q + 4'd1;
      end
      if (em_go) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  // Translation and scale follow the request through the trig units.
  always_ff @(posedge clk_i) begin
    if (start) begin
      tg_tr_q <= q_data_i.tr;
      tg_sc_q <= q_data_i.sc;
    end
  end

  // First rotation stage: all products of two trig values.
  always_ff @(posedge clk_i) begin
    if (take) begin
      r1_czsy_q <= tmul(tg_cos[2], tg_sin[1]);
      r1_szsy_q <= tmul(tg_sin[2], tg_sin[1]);
      r1_rm00_q <= tmul(tg_cos[2], tg_cos[1]);
      r1_rm10_q <= tmul(tg_sin[2], tg_cos[1]);
      r1_rm21_q <= tmul(tg_cos[1], tg_sin[0]);
      r1_rm22_q <= tmul(tg_cos[1], tg_cos[0]);
      r1_szcx_q <= tmul(tg_sin[2], tg_cos[0]);
      r1_szsx_q <= tmul(tg_sin[2], tg_sin[0]);
      r1_czcx_q <= tmul(tg_cos[2], tg_cos[0]);
      r1_czsx_q <= tmul(tg_cos[2], tg_sin[0]);
      r1_sx_q   <= tg_sin[0];
      r1_cx_q   <= tg_cos[0];
      r1_sy_q   <= tg_sin[1];
      r1_tr_q   <= tg_tr_q;
      r1_sc_q   <= tg_sc_q;
    end
  end

  // Second rotation stage: triple products and the sums of R.
  always_ff @(posedge clk_i) begin
    if (r1_move) begin
      r2_rm_q[0][0] <= RM_W'(r1_rm00_q);
      r2_rm_q[0][1] <= -RM_W'(tmul(r1_czsy_q, r1_sx_q)) - RM_W'(r1_szcx_q);
      r2_rm_q[0][2] <= -RM_W'(tmul(r1_czsy_q, r1_cx_q)) + RM_W'(r1_szsx_q);
      r2_rm_q[1][0] <= RM_W'(r1_rm10_q);
      r2_rm_q[1][1] <= -RM_W'(tmul(r1_szsy_q, r1_sx_q)) + RM_W'(r1_czcx_q);
      r2_rm_q[1][2] <= -RM_W'(tmul(r1_szsy_q, r1_cx_q)) - RM_W'(r1_czsx_q);
      r2_rm_q[2][0] <= RM_W'(r1_sy_q);
      r2_rm_q[2][1] <= RM_W'(r1_rm21_q);
      r2_rm_q[2][2] <= RM_W'(r1_rm22_q);
      r2_tr_q       <= r1_tr_q;
      r2_sc_q       <= r1_sc_q;
    end
  end

  // Matrix held by the emitter for its sixteen elements.
  always_ff @(posedge clk_i) begin
    if (r2_move) begin
      em_rm_q <= r2_rm_q;
      em_tr_q <= r2_tr_q;
      em_sc_q <= r2_sc_q;
    end
  end

  // Element value at the current row and column.
  always_comb begin
    logic [1:0] i, j;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    i    = k_q[3:2];
    j    = k_q[1:0];
    prod = '0;
    rnd  = '0;
    if (i == 2'd3) begin
      elem = (j == 2'd3) ? ONE_Q16 : 32'sd0;
    end else if (j == 2'd3) begin
      elem = $signed(em_tr_q[i]);
    end else begin
      prod = em_rm_q[i][j] * $signed(em_sc_q[j]);
      rnd  = (prod + SC_HALF) >>> TRIG_BITS;
      if (rnd > S32_MAX) elem = 32'sh7FFFFFFF;
      else if (rnd < S32_MIN) elem = 32'sh80000000;
      else elem = 32'(rnd);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (em_go) begin
      out_q.row_index     <= k_q[3:2];
      out_q.col_index     <= k_q[1:0];
      out_q.element_value <= elem;
      out_q.last_element  <= (k_q == 4'd15);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/trs_model_matrix_builder.sv
// ============================================================================
// trs_model_matrix_builder: 4x4 translate-rotate-scale model matrix
// Turns translation, Euler angles and scale into sixteen row-major elements.
// ============================================================================
// Each request yields sixteen results, one per cycle while the output is not
// stalled, row-major, with last_element on row 3, column 3. The front takes a
// request every cycle until its three-stage pipeline and two-entry queue are
// full. Sine and cosine come from an iterative Horner unit that works through
// a start state, a squaring state, eight series steps, the finishing states
// FIN and RND and a hand-off for each request, and takes no new request
// before it has handed off the last; the output of the sixteen elements of
// one request overlaps the trig work of the next.
module trs_model_matrix_builder import trsmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic    push, pop;
  q_item_t push_data, pop_data;
  q_stat_t q_stat;

  trsmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_stat.full)
  );

  trsmm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  trsmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_data),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The queue is never written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("queue read while empty");

  // The closing element is the unit corner of the matrix.
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_element |->
      out_data_o.row_index == 2'd3 && out_data_o.col_index == 2'd3 &&
      out_data_o.element_value == ONE_Q16) else $error("bad last element");

  // An accepted element outside column 3, other than the last, is not followed at once by a valid column 0 element.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_element && out_data_o.col_index != 2'd3
      |=> !out_valid_o || out_data_o.col_index != 2'd0) else $error("element order");

endmodule
